// ----- hw/rtl/path_weighted_independent_set_assert.svh -----
// Assertion macros shared by the independent-set block.
// Each takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef PATH_WEIGHTED_INDEPENDENT_SET_ASSERT_SVH
`define PATH_WEIGHTED_INDEPENDENT_SET_ASSERT_SVH

`ifndef SYNTHESIS
`define PWIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwis assertion failed");
`define PWIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwis assertion failed");
`else
`define PWIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PWIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/pwis_pkg.sv -----
package pwis_pkg;

  localparam int WEIGHT_W    = 16;
  localparam int INDEX_W     = 8;
  localparam int QUEUE_DEPTH = 2;

  // one vertex weight along the path
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                final_vertex;
  } in_item_t;

  // one chosen vertex
  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               end_of_set;
  } out_item_t;

  // back end: fill totals, then walk back in read / decide steps
  typedef enum logic [1:0] {
    BK_FILL,
    BK_READ,
    BK_DECIDE
  } back_state_t;

endpackage

// ----- hw/rtl/path_weighted_independent_set.sv -----
// Non-final weight: one per cycle while no walk runs; its total is registered once popped.
// Final weight with n stored vertices: the walk back steps down from vertex n, one pick-flag
// RAM read and one decision per step, and ends with the last index strobed with end_of_set.
// Results appear one per strobe, in descending order; they cannot be stalled.
// busy rises only when the two-entry input queue is full, e.g. while a walk is running.
// Synchronous active-low reset clears control state; no clearing pass is needed.
module path_weighted_independent_set #(
  parameter int MAX_VERTICES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pwis_pkg::in_item_t  in_data,
  output logic                out_valid,
  output pwis_pkg::out_item_t out_data
);

  logic               q_valid;
  logic               q_pop;
  pwis_pkg::in_item_t q_data;

  // accept and queue transactions
  pwis_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // fill totals and walk back
  pwis_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/pwis_ram.sv -----
module pwis_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pwis_front.sv -----
`include "path_weighted_independent_set_assert.svh"

module pwis_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pwis_pkg::in_item_t in_data,
  output logic               q_valid,
  output pwis_pkg::in_item_t q_data,
  input  logic               q_pop
);

  localparam int PW = $clog2(pwis_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(pwis_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(pwis_pkg::QUEUE_DEPTH);

  pwis_pkg::in_item_t q_r [pwis_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;

  // accept a transaction whenever a queue slot is free
  assign busy    = (count_r == FULL_CNT);
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_data  = q_r[rd_ptr_r];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold accepted items
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_data;
    end
  end

  `PWIS_ASSERT_SAME(a_pop_nonempty, clk, rst_n, q_pop, count_r != '0)
  `PWIS_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !q_pop, count_r == $past(count_r) + CW'(1))

endmodule

// ----- hw/rtl/pwis_back.sv -----
`include "path_weighted_independent_set_assert.svh"

module pwis_back #(
  parameter int MAX_VERTICES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pwis_pkg::in_item_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  output pwis_pkg::out_item_t out_data
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int BW = pwis_pkg::WEIGHT_W + $clog2(MAX_VERTICES);
  localparam int IW = pwis_pkg::INDEX_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  pwis_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [BW-1:0] prev1_r, prev1_nxt;
  logic [BW-1:0] prev2_r, prev2_nxt;
  logic          out_valid_r;
  pwis_pkg::out_item_t out_data_r;

  logic [BW-1:0] take, keep;
  logic          take_wins;
  logic          room;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] idx_dec;
  logic          wr_en;
  logic          rd_pick;
  logic          emit_v, emit_end;
  logic          walk_end;
  logic          last_out;

  // candidate total for the incoming weight
  assign take      = prev2_r + BW'(q_data.weight);
  assign keep      = prev1_r;
  assign take_wins = (take > keep);
  assign room      = (cnt_r < MAX_CNT);
  assign cnt_inc   = cnt_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);

  // one pick flag per vertex: set when its total came from taking it
  pwis_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VERTICES)
  ) u_pick_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (take_wins),
    .rd_addr (idx_dec[AW-1:0]),
    .rd_data (rd_pick)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwis_pkg::BK_FILL: begin
        if (q_valid && q_data.final_vertex) begin
          state_nxt = pwis_pkg::BK_READ;
        end
      end
      pwis_pkg::BK_READ: begin
        if (idx_r == '0) begin
          state_nxt = pwis_pkg::BK_FILL;
        end else if (idx_r != CW'(1)) begin
          state_nxt = pwis_pkg::BK_DECIDE;
        end
      end
      pwis_pkg::BK_DECIDE: begin
        state_nxt = pwis_pkg::BK_READ;
      end
      default: begin
        state_nxt = pwis_pkg::BK_FILL;
      end
    endcase
  end

  // datapath and result strobe
  always_comb begin
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    pend_idx_nxt = pend_idx_r;
    pend_v_nxt   = pend_v_r;
    prev1_nxt    = prev1_r;
    prev2_nxt    = prev2_r;
    emit_v       = 1'b0;
    emit_end     = 1'b0;
    unique case (state_r)
      pwis_pkg::BK_FILL: begin
        q_pop = q_valid;
        if (q_valid) begin
          // store the weight's total unless the path is full
          if (room) begin
            wr_en     = 1'b1;
            cnt_nxt   = cnt_inc;
            prev2_nxt = prev1_r;
            prev1_nxt = take_wins ? take : keep;
          end
          if (q_data.final_vertex) begin
            idx_nxt    = room ? cnt_inc : cnt_r;
            pend_v_nxt = 1'b0;
          end
        end
      end
      pwis_pkg::BK_READ: begin
        if (idx_r == '0) begin
          // walk done: release the held pick as the last one, start a new path
          emit_v     = 1'b1;
          emit_end   = 1'b1;
          pend_v_nxt = 1'b0;
          cnt_nxt    = '0;
          prev1_nxt  = '0;
          prev2_nxt  = '0;
        end else if (idx_r == CW'(1)) begin
          // landed on the first vertex: pick it
          emit_v       = pend_v_r;
          pend_idx_nxt = idx_r;
          pend_v_nxt   = 1'b1;
          idx_nxt      = '0;
        end
      end
      pwis_pkg::BK_DECIDE: begin
        if (rd_pick) begin
          emit_v       = pend_v_r;
          pend_idx_nxt = idx_r;
          pend_v_nxt   = 1'b1;
          idx_nxt      = idx_r - CW'(2);
        end else begin
          idx_nxt = idx_dec;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwis_pkg::BK_FILL;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      prev1_r     <= '0;
      prev2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      prev1_r     <= prev1_nxt;
      prev2_r     <= prev2_nxt;
      out_valid_r <= emit_v;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r                   <= idx_nxt;
    pend_idx_r              <= pend_idx_nxt;
    out_data_r.vertex_index <= IW'(pend_idx_r);
    out_data_r.end_of_set   <= emit_end;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // walk end and the closing strobe
  assign walk_end = (state_r == pwis_pkg::BK_READ) && (idx_r == '0);
  assign last_out = out_valid_r && out_data_r.end_of_set;

  `PWIS_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= MAX_CNT)
  `PWIS_ASSERT_SAME(a_decide_idx, clk, rst_n, state_r == pwis_pkg::BK_DECIDE, idx_r > CW'(1))
  `PWIS_ASSERT_NEXT(a_walk_end, clk, rst_n, walk_end, last_out)
  `PWIS_ASSERT_NEXT(a_clear, clk, rst_n, walk_end, state_r == pwis_pkg::BK_FILL && cnt_r == '0)

endmodule
